FILE: design/crfpr_pkg.sv
// Shared types, codes and the byte-wide CRC-16 update for the framed packet receiver.
// No dependencies; every other design file uses this package by scoped names.
`timescale 1ns / 1ps

package crfpr_pkg;

    // Item kinds on the input channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ABORT    = 2'd2;

    // Abort causes
    localparam logic CAUSE_TIMEOUT = 1'b0;
    localparam logic CAUSE_LENGTH  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd267;

    localparam logic [7:0]  SYNC_FIRST  = 8'h55;
    localparam logic [7:0]  SYNC_SECOND = 8'hAA;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'h0000;

    // Frame parser phases, one-hot
    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_SYNC2   = 8'b0000_0010,
        PH_CMD     = 8'b0000_0100,
        PH_LENH    = 8'b0000_1000,
        PH_LENL    = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CRCH    = 8'b0100_0000,
        PH_CRCL    = 8'b1000_0000
    } phase_t;

    // One input item
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } item_t;

    // Input register status toward the parser
    typedef struct packed {
        logic  valid;
        logic  advance;
        item_t item;
    } in_stage_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  command;
        logic [15:0] length;
        logic        crc_ok;
        logic        abort_cause;
    } result_t;

    // CRC-16 XMODEM update by one byte, MSB first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: design/crfpr_in_stage.sv
// Input register for the framed packet receiver: holds one accepted beat.
// Depends on crfpr_pkg.
`timescale 1ns / 1ps

module crfpr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [7:0]         rx_byte,
    input  logic               out_free,
    output crfpr_pkg::in_stage_t stage
);

    logic             valid_reg;
    logic             valid_next;
    crfpr_pkg::item_t item_reg;
    logic             advance;

    // Move the held beat on whenever the result register can take its result
    assign advance  = valid_reg && out_free;
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the payload of an accepted beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op      <= op;
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.advance = advance;
    assign stage.item    = item_reg;

endmodule

FILE: design/crfpr_parser.sv
// Frame parser: phase machine, running CRC, frame fields, idle tick counter
// and the two configuration registers. Depends on crfpr_pkg.
`timescale 1ns / 1ps

module crfpr_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [crfpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    input  crfpr_pkg::in_stage_t   stage,
    output logic                   res_valid,
    output crfpr_pkg::result_t     res
);

    crfpr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  crch_reg, crch_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] timeout_reg;
    logic [15:0] max_len_reg;

    logic [7:0]  b;
    logic [15:0] crc_upd;
    logic [15:0] idle_inc;
    logic [15:0] len_full;
    logic [16:0] count_inc;
    logic [1:0]  kind;
    logic [7:0]  data_b;
    logic [15:0] index_b;
    logic        ok_b;
    logic        cause_b;

    assign b         = stage.item.rx_byte;
    assign crc_upd   = crfpr_pkg::crc_step(crc_reg, b);
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign len_full  = {len_reg[15:8], b};
    assign count_inc = {1'b0, count_reg} + 17'd1;

    // Work out the next state and the result of the held beat
    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        crch_next  = crch_reg;
        idle_next  = idle_reg;
        res_valid  = 1'b0;
        kind       = crfpr_pkg::KIND_PAYLOAD;
        data_b     = 8'h00;
        index_b    = 16'h0000;
        ok_b       = 1'b0;
        cause_b    = crfpr_pkg::CAUSE_TIMEOUT;

        if (stage.item.op == crfpr_pkg::OP_TICK)
        begin
            // Count ticks inside an open frame, abort on timeout
            if (phase_reg == crfpr_pkg::PH_HUNT)
                idle_next = 16'h0000;
            else if (idle_inc >= timeout_reg)
            begin
                res_valid  = 1'b1;
                kind       = crfpr_pkg::KIND_ABORT;
                cause_b    = crfpr_pkg::CAUSE_TIMEOUT;
                phase_next = crfpr_pkg::PH_HUNT;
                idle_next  = 16'h0000;
            end
            else
                idle_next = idle_inc;
        end
        else
        begin
            idle_next = 16'h0000;
            unique case (phase_reg)
                crfpr_pkg::PH_HUNT:
                begin
                    if (b == crfpr_pkg::SYNC_FIRST)
                    begin
                        cmd_next   = 8'h00;
                        len_next   = 16'h0000;
                        count_next = 16'h0000;
                        crch_next  = 8'h00;
                        crc_next   = crfpr_pkg::crc_step(crfpr_pkg::CRC_INIT, b);
                        phase_next = crfpr_pkg::PH_SYNC2;
                    end
                end
                crfpr_pkg::PH_SYNC2:
                begin
                    if (b == crfpr_pkg::SYNC_SECOND)
                    begin
                        crc_next   = crc_upd;
                        phase_next = crfpr_pkg::PH_CMD;
                    end
                    else
                        phase_next = crfpr_pkg::PH_HUNT;
                end
                crfpr_pkg::PH_CMD:
                begin
                    cmd_next   = b;
                    crc_next   = crc_upd;
                    phase_next = crfpr_pkg::PH_LENH;
                end
                crfpr_pkg::PH_LENH:
                begin
                    len_next   = {b, 8'h00};
                    crc_next   = crc_upd;
                    phase_next = crfpr_pkg::PH_LENL;
                end
                crfpr_pkg::PH_LENL:
                begin
                    len_next = len_full;
                    crc_next = crc_upd;
                    if (len_full > max_len_reg)
                    begin
                        res_valid  = 1'b1;
                        kind       = crfpr_pkg::KIND_ABORT;
                        cause_b    = crfpr_pkg::CAUSE_LENGTH;
                        phase_next = crfpr_pkg::PH_HUNT;
                    end
                    else if (len_full == 16'h0000)
                        phase_next = crfpr_pkg::PH_CRCH;
                    else
                        phase_next = crfpr_pkg::PH_PAYLOAD;
                end
                crfpr_pkg::PH_PAYLOAD:
                begin
                    crc_next   = crc_upd;
                    res_valid  = 1'b1;
                    kind       = crfpr_pkg::KIND_PAYLOAD;
                    data_b     = b;
                    index_b    = count_reg;
                    count_next = count_inc[15:0];
                    if (count_inc >= {1'b0, len_reg})
                        phase_next = crfpr_pkg::PH_CRCH;
                end
                crfpr_pkg::PH_CRCH:
                begin
                    crch_next  = b;
                    phase_next = crfpr_pkg::PH_CRCL;
                end
                crfpr_pkg::PH_CRCL:
                begin
                    res_valid  = 1'b1;
                    kind       = crfpr_pkg::KIND_COMPLETE;
                    ok_b       = ({crch_reg, b} == crc_reg);
                    phase_next = crfpr_pkg::PH_HUNT;
                end
                default:
                    phase_next = crfpr_pkg::PH_HUNT;
            endcase
        end
    end

    // Result fields carry the frame header as it stands after this beat
    assign res.kind        = kind;
    assign res.data_byte   = data_b;
    assign res.byte_index  = index_b;
    assign res.command     = cmd_next;
    assign res.length      = len_next;
    assign res.crc_ok      = ok_b;
    assign res.abort_cause = cause_b;

    // Advance frame state on each beat that moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= crfpr_pkg::PH_HUNT;
            crc_reg   <= 16'h0000;
            cmd_reg   <= 8'h00;
            len_reg   <= 16'h0000;
            count_reg <= 16'h0000;
            crch_reg  <= 8'h00;
            idle_reg  <= 16'h0000;
        end
        else if (stage.advance)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            crch_reg  <= crch_next;
            idle_reg  <= idle_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= crfpr_pkg::TIMEOUT_RESET;
            max_len_reg <= crfpr_pkg::MAX_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                crfpr_pkg::REG_BYTE_TIMEOUT: timeout_reg <= cfg_data;
                crfpr_pkg::REG_MAX_PAYLOAD:  max_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: design/crfpr_out_stage.sv
// Result register for the framed packet receiver: holds one result beat
// until the consumer takes it. Depends on crfpr_pkg.
`timescale 1ns / 1ps

module crfpr_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               res_valid,
    input  crfpr_pkg::result_t res,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_ready,
    output crfpr_pkg::result_t out_res
);

    logic               valid_reg;
    logic               valid_next;
    crfpr_pkg::result_t res_reg;

    // Free when empty or when the held beat leaves this cycle
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture a new result beat
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: design/crc_framed_packet_receiver_unit.sv
// Top level of the framed packet receiver: input register, frame parser, result register.
// Depends on crfpr_pkg, crfpr_in_stage, crfpr_parser and crfpr_out_stage.
`timescale 1ns / 1ps

// Takes one item per clock (a received byte or a millisecond tick) unless the
// result register stalls, and gives at most one result per item. Sustained
// rate is one item per cycle while out_ready is high; a result passes through
// the input register, then the result register. The per-item cost is set by the
// byte-wide CRC-16 update and the phase logic, which sit between those two
// registers. in_ready drops only while both registers are full and out_ready is
// low. Configuration writes are taken in any cycle (cfg_ready is always high);
// write them only while no frame work is pending. No clearing pass after reset.
module crc_framed_packet_receiver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [15:0] byte_index,
    output logic [7:0]  command,
    output logic [15:0] length,
    output logic        crc_ok,
    output logic        abort_cause,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [crfpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    crfpr_pkg::in_stage_t stage;
    crfpr_pkg::result_t   res;
    crfpr_pkg::result_t   out_res;
    logic                 res_valid;
    logic                 out_free;

    assign cfg_ready = 1'b1;

    crfpr_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .rx_byte  (rx_byte),
        .out_free (out_free),
        .stage    (stage)
    );

    crfpr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stage     (stage),
        .res_valid (res_valid),
        .res       (res)
    );

    crfpr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage.advance),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind        = out_res.kind;
    assign data_byte   = out_res.data_byte;
    assign byte_index  = out_res.byte_index;
    assign command     = out_res.command;
    assign length      = out_res.length;
    assign crc_ok      = out_res.crc_ok;
    assign abort_cause = out_res.abort_cause;

    // Input backpressure only when both registers are full and the consumer stalls
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage.valid && out_valid && !out_ready))
        else $error("in_ready low without a full pipeline");

    // A payload beat always lies inside the declared length
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == crfpr_pkg::KIND_PAYLOAD) |-> (byte_index < length))
        else $error("payload index beyond frame length");

    // Payload beats carry no status flags
    a_payload_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == crfpr_pkg::KIND_PAYLOAD) |-> (!crc_ok && !abort_cause))
        else $error("status flag set on a payload beat");

    // A length abort reports a length above zero
    a_len_abort: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == crfpr_pkg::KIND_ABORT
            && abort_cause == crfpr_pkg::CAUSE_LENGTH) |-> (length != 16'h0000))
        else $error("length abort with zero length");

endmodule
